### src/index_homing_offset_estimator_defines.svh
// Assertion helpers for the homing estimator
`ifndef INDEX_HOMING_OFFSET_ESTIMATOR_DEFINES_SVH
`define INDEX_HOMING_OFFSET_ESTIMATOR_DEFINES_SVH

// check a property on every clock outside reset
`define IHOE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check a property on every clock, reset included
`define IHOE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/ihoe_pkg.sv
`timescale 1ns / 1ps
package ihoe_pkg;

  localparam int unsigned SlotCount = 4;
  localparam logic signed [23:0] PiQ = 24'sd205887;
  localparam logic signed [23:0] HalfPiQ = 24'sd102944;
  localparam logic signed [23:0] TwoPiQ = 24'sd411775;
  localparam logic signed [39:0] CordicGainQ = 40'sd39797;
  localparam logic [11:0] GearRatioReset = 12'd147;

  localparam logic [1:0] CfgGearRatio = 2'd0;
  localparam logic [1:0] CfgHomeIndexAngle = 2'd1;

  typedef enum logic [1:0] {
    OP_EDGE = 2'd0,
    OP_TICK = 2'd1,
    OP_RESET = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CAL_LOST = 2'd0,
    CAL_MEASURING = 2'd1,
    CAL_HOMED = 2'd2,
    CAL_BAD = 2'd3
  } calib_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_REDUCE,
    S_WRAP,
    S_FOLD,
    S_ROT,
    S_ACCUM,
    S_VEC_INIT,
    S_VEC,
    S_MUL,
    S_DONE
  } seq_t;

  typedef struct packed {
    logic [1:0] op;
    logic index_level;
    logic signed [31:0] sample_position;
    logic moving_forward;
    logic [1:0] target_state;
  } in_item_t;

  typedef struct packed {
    logic [1:0] homed_state;
    logic estimate_ok;
    logic signed [31:0] home_offset;
  } out_item_t;

  // request to the CORDIC unit
  typedef struct packed {
    logic start;
    logic vectoring;
  } cordic_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cordic_sts_t;

  function automatic logic signed [23:0] atan_q(input logic [4:0] i);
    logic signed [23:0] r;
    r = '0;
    case (i)
      5'd0: r = 24'sd51472;
      5'd1: r = 24'sd30386;
      5'd2: r = 24'sd16055;
      5'd3: r = 24'sd8150;
      5'd4: r = 24'sd4091;
      5'd5: r = 24'sd2047;
      5'd6: r = 24'sd1024;
      5'd7: r = 24'sd512;
      5'd8: r = 24'sd256;
      5'd9: r = 24'sd128;
      5'd10: r = 24'sd64;
      5'd11: r = 24'sd32;
      5'd12: r = 24'sd16;
      5'd13: r = 24'sd8;
      5'd14: r = 24'sd4;
      5'd15: r = 24'sd2;
      5'd16: r = 24'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### src/ihoe_cordic.sv
`timescale 1ns / 1ps
`include "index_homing_offset_estimator_defines.svh"
module ihoe_cordic import ihoe_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic clk,
  input  logic rst,
  input  cordic_ctl_t ctl,
  input  logic signed [39:0] x_init,
  input  logic signed [39:0] y_init,
  input  logic signed [23:0] z_init,
  output cordic_sts_t sts,
  output logic signed [39:0] x_out,
  output logic signed [39:0] y_out,
  output logic signed [23:0] z_out
);
  localparam int unsigned StepW = $clog2(CORDIC_STEPS + 1);

  logic signed [39:0] x, y;
  logic signed [23:0] z;
  logic [StepW-1:0] step;
  logic busy, done, mode_vec;
  logic dir_pos;
  logic signed [39:0] xs, ys;
  logic signed [23:0] a;

  // arithmetic shift floors, as required
  assign xs = x >>> step;
  assign ys = y >>> step;
  assign a = atan_q(5'(step));
  assign dir_pos = mode_vec ? (y > 0) : (z >= 0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
      mode_vec <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start && !busy) begin
        busy <= 1'b1;
        step <= '0;
        mode_vec <= ctl.vectoring;
      end else if (busy) begin
        if (step == StepW'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start && !busy) begin
      x <= x_init;
      y <= y_init;
      z <= z_init;
    end else if (busy) begin
      if (mode_vec != dir_pos) begin
        // rotation with z>=0, or vectoring with y<=0
        x <= x - ys;
        y <= y + xs;
        z <= z - a;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + a;
      end
    end
  end

  assign sts = '{busy: busy, done: done};
  assign x_out = x;
  assign y_out = y;
  assign z_out = z;

  `IHOE_ASSERT(a_done_after_busy, done |-> $past(busy), "done without a run")
  `IHOE_ASSERT(a_no_restart, (busy && ctl.start) |=> busy || done, "restart during run")
  `IHOE_ASSERT_ALWAYS(a_not_both, rst || !(busy && done), "busy and done together")
endmodule

### src/index_homing_offset_estimator.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid/in_ready   | in_item_t (op, level, position, dir, target)
// out     | output    | out_valid/out_ready | out_item_t (state, ok, offset)
// cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Edge, reset and idle ticks pass through S_DONE, which registers out_valid.
// An estimating tick runs, per slot: a restoring divide, a 13-step
// compare-and-subtract reduction by 2*pi plus a wrap, a fold and a CORDIC_STEPS
// rotation on the shared CORDIC; then one vectoring pass and a multiply. The
// vectoring pass is skipped when both sums are zero. The slots share the one
// divider and the single CORDIC.
// One item is in flight at a time; in_ready drops until the result transfers.
// rst is synchronous: state lost, slots invalid, ratio 147, index angle 0.
`include "index_homing_offset_estimator_defines.svh"
module index_homing_offset_estimator import ihoe_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_item_t in_item,
  output logic out_valid,
  input  logic out_ready,
  output out_item_t out_item,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [31:0] cfg_data
);
  // configuration
  logic [11:0] gear_ratio;
  logic signed [18:0] home_index_angle;

  // calibration state
  logic [SlotCount-1:0] slot_valid;
  logic signed [31:0] slot_position [SlotCount];
  calib_t calib_state;
  logic fresh_data;
  logic signed [31:0] offset_value;

  // sequencer
  seq_t seq, seq_next;
  logic [1:0] k;            // slot order counter
  logic [5:0] div_cnt;
  logic [31:0] quot;        // magnitude quotient, then its remainder by 2*pi
  logic [31:0] dividend;    // magnitude being shifted out
  logic [12:0] rem;
  logic neg_q;
  logic signed [23:0] ang;
  logic neg_sc;
  logic signed [39:0] ssum, csum;
  logic estimate_ok;
  logic est_run;
  logic signed [43:0] prod;

  cordic_ctl_t cctl;
  cordic_sts_t csts;
  logic signed [39:0] cx_init, cy_init, cx, cy;
  logic signed [23:0] cz_init, cz;

  logic [11:0] ratio;
  logic [1:0] slot_sel;
  logic signed [31:0] pos_sel;
  logic [12:0] rem_try;
  logic [32:0] red_step;
  logic signed [24:0] rsgn;
  logic signed [23:0] ang_fold;
  logic signed [23:0] diff;
  logic signed [39:0] vx, vy;
  logic est_start;

  assign ratio = (gear_ratio == 12'd0) ? 12'd1 : gear_ratio;
  assign cfg_ready = 1'b1;
  assign in_ready = (seq == S_IDLE) && !out_valid;

  // a tick estimates only with fresh data, while measuring, with all slots filled
  assign est_start = (in_item.op == OP_TICK) && fresh_data
                     && (calib_state == CAL_MEASURING) && (&slot_valid);

  // slot order 3,0,1,2
  assign slot_sel = k - 2'd1;
  assign pos_sel = slot_position[slot_sel];
  assign rem_try = {rem[11:0], dividend[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      gear_ratio <= GearRatioReset;
      home_index_angle <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CfgGearRatio: gear_ratio <= cfg_data[11:0];
        CfgHomeIndexAngle: home_index_angle <= cfg_data[18:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) seq <= S_IDLE;
    else seq <= seq_next;
  end

  // next-state logic
  always_comb begin
    seq_next = seq;
    unique case (seq)
      S_IDLE: if (in_valid && in_ready) begin
        if (est_start) seq_next = S_DIV;
        else seq_next = S_DONE;
      end
      S_DIV: if (div_cnt == 6'd32) seq_next = S_REDUCE;
      S_REDUCE: if (div_cnt == 6'd12) seq_next = S_WRAP;
      S_WRAP: seq_next = S_FOLD;
      S_FOLD: seq_next = S_ROT;
      S_ROT: if (csts.done) seq_next = S_ACCUM;
      S_ACCUM: seq_next = (k == 2'd3) ? S_VEC_INIT : S_DIV;
      S_VEC_INIT: seq_next = (ssum == 0 && csum == 0) ? S_MUL : S_VEC;
      S_VEC: if (csts.done) seq_next = S_MUL;
      S_MUL: seq_next = S_DONE;
      S_DONE: seq_next = S_IDLE;
      default: seq_next = S_IDLE;
    endcase
  end

  // reduce the quotient magnitude by 2*pi shifted left 12 down to 0, one per cycle
  assign red_step = {9'd0, TwoPiQ} << (4'd12 - div_cnt[3:0]);
  // remainder takes the sign of the quotient
  assign rsgn = neg_q ? -$signed({1'b0, quot[23:0]}) : $signed({1'b0, quot[23:0]});
  // fold into +-pi/2; sin and cos get negated when folded
  assign ang_fold = (ang > HalfPiQ) ? ang - PiQ : (ang < -HalfPiQ) ? ang + PiQ : ang;
  assign diff = cz - 24'(home_index_angle);

  assign cctl.start = (seq == S_FOLD) || (seq == S_VEC_INIT && !(ssum == 0 && csum == 0));
  assign cctl.vectoring = (seq == S_VEC_INIT);

  always_comb begin
    vx = csum <<< 8;
    vy = ssum <<< 8;
    cz_init = ang_fold;
    if (seq == S_VEC_INIT) begin
      cz_init = '0;
      if (vx < 0) begin
        if (vy >= 0) begin
          vx = ssum <<< 8;
          vy = -(csum <<< 8);
          cz_init = HalfPiQ;
        end else begin
          vx = -(ssum <<< 8);
          vy = csum <<< 8;
          cz_init = -HalfPiQ;
        end
      end
    end
    cx_init = (seq == S_VEC_INIT) ? vx : CordicGainQ;
    cy_init = (seq == S_VEC_INIT) ? vy : 40'sd0;
  end

  ihoe_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .ctl(cctl),
    .x_init(cx_init), .y_init(cy_init), .z_init(cz_init),
    .sts(csts), .x_out(cx), .y_out(cy), .z_out(cz)
  );

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      calib_state <= CAL_LOST;
      fresh_data <= 1'b0;
      offset_value <= '0;
      out_valid <= 1'b0;
      estimate_ok <= 1'b0;
      est_run <= 1'b0;
      k <= '0;
      div_cnt <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (seq)
        S_IDLE: if (in_valid && in_ready) begin
          estimate_ok <= 1'b0;
          est_run <= est_start;
          k <= '0;
          div_cnt <= '0;
          ssum <= '0;
          csum <= '0;
          case (op_t'(in_item.op))
            OP_EDGE: if (calib_state != CAL_LOST) begin
              slot_valid[{in_item.moving_forward, in_item.index_level}] <= 1'b1;
              slot_position[{in_item.moving_forward, in_item.index_level}]
                <= in_item.sample_position;
              fresh_data <= 1'b1;
            end
            OP_TICK: fresh_data <= 1'b0;
            OP_RESET: begin
              slot_valid <= '0;
              calib_state <= (in_item.target_state == CAL_BAD) ? CAL_LOST
                                                              : calib_t'(in_item.target_state);
            end
            default: ;
          endcase
        end
        S_DIV: begin
          if (div_cnt == 6'd0) begin
            neg_q <= pos_sel[31];
            dividend <= pos_sel[31] ? 32'(-pos_sel) : pos_sel;
            rem <= '0;
            quot <= '0;
          end else begin
            if (rem_try >= {1'b0, ratio}) begin
              rem <= rem_try - {1'b0, ratio};
              quot <= {quot[30:0], 1'b1};
            end else begin
              rem <= rem_try;
              quot <= {quot[30:0], 1'b0};
            end
            dividend <= {dividend[30:0], 1'b0};
          end
          div_cnt <= (div_cnt == 6'd32) ? 6'd0 : div_cnt + 6'd1;
        end
        S_REDUCE: begin
          if ({1'b0, quot} >= red_step) quot <= quot - red_step[31:0];
          div_cnt <= (div_cnt == 6'd12) ? 6'd0 : div_cnt + 6'd1;
        end
        S_WRAP: begin
          ang <= (rsgn > 25'(PiQ)) ? 24'(rsgn - 25'(TwoPiQ))
               : (rsgn < -25'(PiQ)) ? 24'(rsgn + 25'(TwoPiQ)) : 24'(rsgn);
        end
        S_FOLD: begin
          neg_sc <= 1'b0;
          if (ang > HalfPiQ) begin
            ang <= ang - PiQ;
            neg_sc <= 1'b1;
          end else if (ang < -HalfPiQ) begin
            ang <= ang + PiQ;
            neg_sc <= 1'b1;
          end
        end
        S_ACCUM: begin
          ssum <= neg_sc ? ssum - cy : ssum + cy;
          csum <= neg_sc ? csum - cx : csum + cx;
          k <= k + 2'd1;
        end
        S_MUL: begin
          if (ssum == 0 && csum == 0)
            prod <= -44'(home_index_angle) * $signed({32'd0, ratio});
          else
            prod <= 44'(diff) * $signed({32'd0, ratio});
        end
        S_DONE: begin
          if (est_run) begin
            offset_value <= (prod > 44'sd2147483647) ? 32'sh7fffffff
                          : (prod < -44'sd2147483648) ? 32'sh80000000 : prod[31:0];
            calib_state <= CAL_HOMED;
            estimate_ok <= 1'b1;
          end
          out_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_item.homed_state = calib_state;
    out_item.estimate_ok = estimate_ok;
    out_item.home_offset = offset_value;
  end

  `IHOE_ASSERT(a_ready_idle, in_ready |-> (seq == S_IDLE), "ready while busy")
  `IHOE_ASSERT(a_one_item, (in_valid && in_ready) |=> !in_ready, "second transfer accepted")
  `IHOE_ASSERT(a_ok_homed, (out_valid && out_item.estimate_ok) |-> (calib_state == CAL_HOMED),
    "estimate without homed state")
endmodule
